FILE: rtl/core/shfp_pkg.sv
// ----------------------------------------------------------------------------
// Sync-header frame parser package
// Shared payload types, result kinds and register defaults.
// ----------------------------------------------------------------------------
package shfp_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_TAIL_VALUE    = 2'd2;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'hF0;
    localparam logic [7:0] HEADER_SECOND_RST = 8'hF1;
    localparam logic [7:0] TAIL_VALUE_RST    = 8'hEC;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FRAME   = 2'd1;
    localparam logic [1:0] KIND_NOHEAD  = 2'd2;
    localparam logic [1:0] KIND_NOTAIL  = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [15:0] declared_length;
        logic [15:0] payload_count;
        logic        last;
    } t_out;

endpackage

FILE: rtl/core/sync_header_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Sync-header frame parser
// Hunts for a two-byte header, takes command and length, forwards payload up
// to the tail byte and reports the frame, or an error at end of message or on count overflow.
// ----------------------------------------------------------------------------
// One byte request is taken per clock while the queue is not full, and is
// parsed in the same cycle into a two-entry result queue; its results appear
// from the next cycle on. A byte gives at most one result, except a payload
// byte that also ends the message, which gives the byte and then a
// missing-tail report: its entry holds a queue slot until both results are
// taken, so the input may stall while the queue drains. The rate of one byte
// per cycle is limited only by the one result output and the two-entry queue.
module sync_header_frame_parser_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  shfp_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output shfp_pkg::t_out   o_out_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT1   = 3'd0,
        PH_HUNT2   = 3'd1,
        PH_CMD     = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    // One queue entry holds everything a single request produced
    typedef struct packed {
        logic        pay_vld;
        logic [7:0]  pay_byte;
        logic        st_vld;
        logic [1:0]  st_kind;
        logic [7:0]  command;
        logic [15:0] dlen;
        logic [15:0] count;
    } t_entry;

    logic [7:0]  r_hdr1;
    logic [7:0]  r_hdr2;
    logic [7:0]  r_tail;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;

    t_entry      r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_count;
    logic        r_sub;

    t_entry      w_ent;
    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_push;
    logic        w_pop;
    logic        w_emit_pay;
    t_entry      w_head;

    assign o_in_stall = (r_count == 2'd2);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_push     = w_in_acc && (w_ent.pay_vld || w_ent.st_vld);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_cnt   = r_cnt;
        w_ent   = '0;
        case (r_phase)
            PH_HUNT1: begin
                if (i_in_data.data_byte == r_hdr1) n_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                if (i_in_data.data_byte == r_hdr2) n_phase = PH_CMD;
                else if (i_in_data.data_byte != r_hdr1) n_phase = PH_HUNT1;
            end
            PH_CMD: begin
                n_cmd   = i_in_data.data_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = {8'h00, i_in_data.data_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_in_data.data_byte, r_len[7:0]};
                n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (i_in_data.data_byte == r_tail) begin
                    w_ent.st_vld  = 1'b1;
                    w_ent.st_kind = shfp_pkg::KIND_FRAME;
                    w_ent.command = r_cmd;
                    w_ent.dlen    = r_len;
                    w_ent.count   = r_cnt;
                    n_phase       = PH_DONE;
                end else if (r_cnt == shfp_pkg::COUNT_MAX) begin
                    // count would wrap: drop the byte and flag the frame
                    w_ent.st_vld  = 1'b1;
                    w_ent.st_kind = shfp_pkg::KIND_NOTAIL;
                    n_phase       = PH_DONE;
                end else begin
                    w_ent.pay_vld  = 1'b1;
                    w_ent.pay_byte = i_in_data.data_byte;
                    n_cnt          = r_cnt + 16'd1;
                end
            end
            default: ;
        endcase

        if (i_in_data.end_of_message) begin
            if (n_phase == PH_HUNT1 || n_phase == PH_HUNT2) begin
                w_ent.st_vld  = 1'b1;
                w_ent.st_kind = shfp_pkg::KIND_NOHEAD;
            end else if (n_phase != PH_DONE) begin
                w_ent.st_vld  = 1'b1;
                w_ent.st_kind = shfp_pkg::KIND_NOTAIL;
            end
            n_phase = PH_HUNT1;
            n_cmd   = '0;
            n_len   = '0;
            n_cnt   = '0;
        end
    end

    // Output side: payload byte first, then the status of the same request
    assign w_head      = r_q[r_rp];
    assign o_out_valid = (r_count != 2'd0);
    assign w_emit_pay  = w_head.pay_vld && !r_sub;
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_pop       = w_out_acc && o_out_data.last;

    always_comb begin
        o_out_data = '0;
        if (w_emit_pay) begin
            o_out_data.kind         = shfp_pkg::KIND_PAYLOAD;
            o_out_data.payload_byte = w_head.pay_byte;
            o_out_data.last         = !w_head.st_vld;
        end else begin
            o_out_data.kind            = w_head.st_kind;
            o_out_data.command         = w_head.command;
            o_out_data.declared_length = w_head.dlen;
            o_out_data.payload_count   = w_head.count;
            o_out_data.last            = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1  <= shfp_pkg::HEADER_FIRST_RST;
            r_hdr2  <= shfp_pkg::HEADER_SECOND_RST;
            r_tail  <= shfp_pkg::TAIL_VALUE_RST;
            r_phase <= PH_HUNT1;
            r_cmd   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    shfp_pkg::CFG_HEADER_FIRST:  r_hdr1 <= i_cfg_data;
                    shfp_pkg::CFG_HEADER_SECOND: r_hdr2 <= i_cfg_data;
                    shfp_pkg::CFG_TAIL_VALUE:    r_tail <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
            end
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
            // advance to the status half once the payload byte is taken
            if (w_pop) r_sub <= 1'b0;
            else if (w_out_acc) r_sub <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_ent;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue overfilled");

    a_sub_needs_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (o_out_valid && w_head.pay_vld && w_head.st_vld))
        else $error("second half of an entry without a status result");

    a_eom_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.end_of_message) |=> (r_phase == PH_HUNT1 && r_cnt == 16'd0))
        else $error("end of message did not clear the parser state");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (w_head.pay_vld || w_head.st_vld))
        else $error("empty entry in result queue");

    a_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == shfp_pkg::KIND_FRAME) |-> o_out_data.last)
        else $error("frame report not marked last");

endmodule
